// ===== rtl/work_stealing_task_queues_defines.svh =====
// Assertion macros for the work-stealing task queue block.
// Needs a clock named clk and a synchronous reset named rst in the using module.
`ifndef WORK_STEALING_TASK_QUEUES_DEFINES_SVH
`define WORK_STEALING_TASK_QUEUES_DEFINES_SVH

// Same-cycle or delayed implication, checked outside reset
`define WSTQ_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define WSTQ_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wstq_pkg.sv =====
// Shared types and codes for the work-stealing task queue block.
// No dependencies; used by work_stealing_task_queues.
package wstq_pkg;

  // Command codes
  typedef enum logic [0:0] {
    CMD_SPAWN = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [0:0] REG_ACTIVE_WORKERS = 1'b0;
  localparam logic [3:0] ACTIVE_WORKERS_RST = 4'd8;

  // Input item
  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  worker_id;
    logic [31:0] task_token;
  } wstq_req_t;

  // Result item
  typedef struct packed {
    status_t     status;
    logic [31:0] task_out;
    logic [2:0]  source_worker;
    logic        was_stolen;
  } wstq_rsp_t;

endpackage

// ===== rtl/work_stealing_task_queues.sv =====
// The result strobe (done) rises in S_RESP, after the item leaves S_EXEC, for one cycle.
// busy is high only in the execute cycle, in which the single-port ring memory with its registered
// read makes one access per item. A new start may coincide with done, while the last result shows.
// The receiver cannot stall. Reset clears pointers, the spawn pointer and sets
// active_workers to 8; ring contents stay undefined, so there is no clearing pass.
// Top level of the work-stealing task queue block; depends on wstq_pkg and the defines header.
`include "work_stealing_task_queues_defines.svh"

module work_stealing_task_queues
  import wstq_pkg::*;
#(
  parameter int NUM_WORKERS = 8,
  parameter int DEQUE_DEPTH = 32,
  parameter int TOKEN_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  wstq_req_t   req,
  output logic        done,
  output wstq_rsp_t   rsp,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WIDX_W  = $clog2(NUM_WORKERS);
  localparam int CNT_RAW = $clog2(NUM_WORKERS + 1);
  localparam int AW      = (CNT_RAW > 4) ? CNT_RAW : 4;
  localparam int SL_W    = $clog2(DEQUE_DEPTH);
  localparam int PW      = SL_W + 1;
  localparam int TW      = TOKEN_WIDTH;
  localparam int RING_D  = NUM_WORKERS * DEQUE_DEPTH;
  localparam int AD_W    = $clog2(RING_D);

  localparam logic [PW-1:0] PTR_MAX  = PW'(2 * DEQUE_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(DEQUE_DEPTH);
  localparam logic [PW:0]   SPAN_F   = (PW+1)'(2 * DEQUE_DEPTH);
  localparam logic [PW:0]   DEPTH_F  = (PW+1)'(DEQUE_DEPTH);
  localparam logic [AW-1:0] NW_A     = AW'(NUM_WORKERS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  // Pointer helpers: pointers count modulo twice the deque depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_MAX) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PTR_MAX : p - PW'(1);
  endfunction

  function automatic logic [SL_W-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    ptr_slot = s[SL_W-1:0];
  endfunction

  function automatic logic [PW:0] fill_of(input logic [PW-1:0] b, input logic [PW-1:0] t);
    if (b >= t) begin
      fill_of = {1'b0, b} - {1'b0, t};
    end else begin
      fill_of = {1'b0, b} + SPAN_F - {1'b0, t};
    end
  endfunction

  state_t            state, state_next;
  wstq_req_t         req_q;
  logic [3:0]        active_workers;
  logic [PW-1:0]     top_ptr [NUM_WORKERS];
  logic [PW-1:0]     bot_ptr [NUM_WORKERS];
  logic [WIDX_W-1:0] spawn_ptr;

  logic [TW-1:0]     ring [RING_D];
  logic [TW-1:0]     rd_data;

  logic              accept;
  logic              exec;
  logic              cfg_wr;
  logic [AW-1:0]     act_ext;
  logic [AW-1:0]     n_act;
  logic [AW-1:0]     wid_ext;
  logic [WIDX_W-1:0] wid_idx;
  logic [AW-1:0]     sp_ext;
  logic [AW-1:0]     tgt_ext;
  logic [AW-1:0]     tgt_inc;
  logic [WIDX_W-1:0] tgt_idx;
  logic [WIDX_W-1:0] sp_next;
  logic              tgt_full;
  logic [NUM_WORKERS-1:0] nonempty;
  logic [NUM_WORKERS-1:0] mask_hi;
  logic [NUM_WORKERS-1:0] mask_lo;
  logic              vic_found;
  logic [WIDX_W-1:0] vic_idx;
  logic              fetch_ok;

  // Decision of the execute cycle
  logic              do_push;
  logic              do_pop;
  logic              do_steal;
  logic [WIDX_W-1:0] sel_w;
  logic [PW-1:0]     sel_p;
  logic [AD_W-1:0]   mem_addr;
  logic [TW-1:0]     mem_wdata;
  logic [TW+31:0]    tok_wide;
  logic [TW+31:0]    rd_wide;
  logic [WIDX_W+2:0] src_wide;
  status_t           st_next;
  logic [2:0]        src_next;

  // Result registers
  status_t           rsp_status;
  logic [2:0]        rsp_src;
  logic              rsp_stolen;
  logic              rsp_hit;

  assign accept = start && !busy;
  assign exec   = (state == S_EXEC);
  assign busy   = exec;
  assign done   = (state == S_RESP);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Configuration read data
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE_WORKERS) begin
      prdata = {28'd0, active_workers};
    end
  end

  // Clamp the active worker count into 1..NUM_WORKERS
  always_comb begin
    act_ext = AW'(active_workers);
    if (act_ext == '0) begin
      n_act = AW'(1);
    end else if (act_ext > NW_A) begin
      n_act = NW_A;
    end else begin
      n_act = act_ext;
    end
  end

  // Requester and round-robin spawn target
  assign wid_ext  = AW'(req_q.worker_id);
  assign wid_idx  = wid_ext[WIDX_W-1:0];
  assign sp_ext   = AW'(spawn_ptr);
  assign tgt_ext  = (sp_ext < n_act) ? sp_ext : '0;
  assign tgt_idx  = tgt_ext[WIDX_W-1:0];
  assign tgt_inc  = tgt_ext + AW'(1);
  assign sp_next  = (tgt_inc == n_act) ? '0 : tgt_inc[WIDX_W-1:0];
  assign tgt_full = fill_of(bot_ptr[tgt_idx], top_ptr[tgt_idx]) >= DEPTH_F;
  assign fetch_ok = (req_q.cmd == CMD_FETCH) && (wid_ext < n_act);

  // Check all deques for emptiness at once and split the victim scan around the requester
  always_comb begin
    for (int i = 0; i < NUM_WORKERS; i++) begin
      nonempty[i] = (bot_ptr[i] != top_ptr[i]);
      mask_hi[i]  = nonempty[i] && (AW'(i) > wid_ext) && (AW'(i) < n_act);
      mask_lo[i]  = nonempty[i] && (AW'(i) < wid_ext);
    end
  end

  // Pick the first victim after the requester, wrapping to worker zero
  always_comb begin
    vic_found = 1'b0;
    vic_idx   = '0;
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if (mask_lo[i]) begin
        vic_found = 1'b1;
        vic_idx   = WIDX_W'(i);
      end
    end
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if (mask_hi[i]) begin
        vic_found = 1'b1;
        vic_idx   = WIDX_W'(i);
      end
    end
  end

  // Decide the operation and the ring access
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_steal = 1'b0;
    sel_w    = tgt_idx;
    sel_p    = bot_ptr[tgt_idx];
    st_next  = ST_EMPTY;
    src_wide = '0;
    src_next = req_q.worker_id;
    priority if (req_q.cmd == CMD_SPAWN) begin
      src_wide = {3'b000, tgt_idx};
      src_next = src_wide[2:0];
      if (tgt_full) begin
        st_next = ST_FULL;
      end else begin
        st_next = ST_OK;
        do_push = 1'b1;
      end
    end else if (fetch_ok && nonempty[wid_idx]) begin
      do_pop  = 1'b1;
      st_next = ST_OK;
      sel_w   = wid_idx;
      sel_p   = ptr_dec(bot_ptr[wid_idx]);
    end else if (fetch_ok && vic_found) begin
      do_steal = 1'b1;
      st_next  = ST_OK;
      sel_w    = vic_idx;
      sel_p    = top_ptr[vic_idx];
      src_wide = {3'b000, vic_idx};
      src_next = src_wide[2:0];
    end else begin
      st_next = ST_EMPTY;
    end
  end

  assign mem_addr  = AD_W'(sel_w) * AD_W'(DEQUE_DEPTH) + AD_W'(ptr_slot(sel_p));
  assign tok_wide  = {{TW{1'b0}}, req_q.task_token};
  assign mem_wdata = tok_wide[TW-1:0];

  // Ring memory: one access per item, registered read
  always_ff @(posedge clk) begin
    if (exec && do_push) begin
      ring[mem_addr] <= mem_wdata;
    end
    if (exec && (do_pop || do_steal)) begin
      rd_data <= ring[mem_addr];
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, pointers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      spawn_ptr      <= '0;
      active_workers <= ACTIVE_WORKERS_RST;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        top_ptr[i] <= '0;
        bot_ptr[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr && (paddr[2] == REG_ACTIVE_WORKERS)) begin
        active_workers <= pwdata[3:0];
      end
      if (exec) begin
        if (req_q.cmd == CMD_SPAWN) begin
          spawn_ptr <= sp_next;
        end
        if (do_push) begin
          bot_ptr[sel_w] <= ptr_inc(bot_ptr[sel_w]);
        end
        if (do_pop) begin
          bot_ptr[sel_w] <= sel_p;
        end
        if (do_steal) begin
          top_ptr[sel_w] <= ptr_inc(sel_p);
        end
      end
    end
  end

  // Hold the request and the result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (exec) begin
      rsp_status <= st_next;
      rsp_src    <= src_next;
      rsp_stolen <= do_steal;
      rsp_hit    <= do_pop || do_steal;
    end
  end

  // Drive the result transfer
  assign rd_wide = {32'd0, rd_data};
  always_comb begin
    rsp.status        = rsp_status;
    rsp.task_out      = rsp_hit ? rd_wide[31:0] : 32'd0;
    rsp.source_worker = rsp_src;
    rsp.was_stolen    = rsp_stolen;
  end

  `WSTQ_CHECK(a_accept_to_done, start && !busy, ##2 done, "result strobe not two cycles after start")
  `WSTQ_CHECK_NEXT(a_exec_one_cycle, busy, !busy && done, "execute cycle did not end in a result")
  `WSTQ_CHECK(a_done_after_exec, done, $past(busy), "result without an execute cycle")
  `WSTQ_CHECK(a_miss_zero_token, done && (rsp.status != ST_OK), rsp.task_out == 32'd0 && !rsp.was_stolen, "failed item carries a token")

endmodule
